/* sv/yuvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// yuvrgb_pkg
// Shared types, register codes and conversion constants for the YUV to RGBA
// converter with flip and rotation addressing.
// ----------------------------------------------------------------------------
package yuvrgb_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_HORIZONTAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_VERTICAL   = 3'd4;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    // pixel format
    localparam int PIX_W   = 8;
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 24;
    localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // fixed-point color math, 8 fractional bits
    localparam int PROD_W   = 18;
    localparam int FRAC_W   = 8;
    localparam logic signed [PROD_W-1:0] COEF_RV = 18'sd351;
    localparam logic signed [PROD_W-1:0] COEF_GU = 18'sd88;
    localparam logic signed [PROD_W-1:0] COEF_GV = 18'sd183;
    localparam logic signed [PROD_W-1:0] COEF_BU = 18'sd454;
    localparam logic signed [PIX_W:0]    CHROMA_OFFSET = 9'sd128;

    // per-stage load enables of the datapath pipeline
    typedef struct packed {
        logic ld2;
        logic ld3;
    } t_pipe_ctl;

    function automatic logic [PIX_W-1:0] sat8(input logic signed [PROD_W-1:0] x);
        logic [PIX_W-1:0] res;
        if (x < 0) begin
            res = '0;
        end else if (x > 18'sd255) begin
            res = 8'hFF;
        end else begin
            res = x[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

/* sv/yuv_to_rgba_rotate_flip.sv */
// An accepted input item is registered in stage 1, then stage 2, then stage 3, which drives the output.
// Throughput: one item per cycle; the three-stage pipeline stalls only when
// the output register is full and the consumer asserts i_out_stall.
// Reset (synchronous, active low): pipeline emptied, column and row counters
// cleared, registers back to 640x480, no rotation, no mirroring.
// ----------------------------------------------------------------------------
// yuv_to_rgba_rotate_flip
// Streaming YUV to packed RGBA converter that tags each pixel with its
// destination index after optional mirroring and clockwise rotation.
// ----------------------------------------------------------------------------
module yuv_to_rgba_rotate_flip #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [yuvrgb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [yuvrgb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [yuvrgb_pkg::PIX_W-1:0]        i_luma,
    input  logic [yuvrgb_pkg::PIX_W-1:0]        i_chroma_blue,
    input  logic [yuvrgb_pkg::PIX_W-1:0]        i_chroma_red,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [yuvrgb_pkg::WORD_W-1:0]       o_pixel_word,
    output logic [yuvrgb_pkg::INDEX_W-1:0]      o_dest_index,
    output logic                                o_frame_last
);
    // DW holds a frame size up to MAX_DIM, CW a position below it
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int CW = $clog2(MAX_DIM);

    logic [DW-1:0]         cfg_width, cfg_height;
    yuvrgb_pkg::t_rot      cfg_rot;
    logic                  cfg_flip_h, cfg_flip_v;

    yuvrgb_pkg::t_pipe_ctl pipe_ctl;
    logic                  ld1, accept;
    logic                  r_v1, r_v2, r_v3;

    logic [CW-1:0]         r_col, r_row;
    logic [CW-1:0]         col_eff, row_eff;
    logic                  col_end, row_end;
    logic [CW-1:0]         n_col, n_row;

    logic [yuvrgb_pkg::PIX_W-1:0] r1_luma, r1_cb, r1_cr;
    logic [CW-1:0]         r1_col, r1_row;
    logic                  r1_last;

    yuvrgb_cfg #(
        .MAX_DIM (MAX_DIM),
        .DW      (DW)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_width    (cfg_width),
        .o_height   (cfg_height),
        .o_rot      (cfg_rot),
        .o_flip_h   (cfg_flip_h),
        .o_flip_v   (cfg_flip_v)
    );

    // Each stage loads when it is empty or its contents move on; a full
    // output held by the consumer backs up through all three stages.
    always_comb begin
        pipe_ctl.ld3 = !r_v3 || !i_out_stall;
        pipe_ctl.ld2 = !r_v2 || pipe_ctl.ld3;
        ld1          = !r_v1 || pipe_ctl.ld2;
    end

    assign o_in_stall = !ld1;
    assign accept     = i_in_valid && ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld1)          r_v1 <= i_in_valid;
            if (pipe_ctl.ld2) r_v2 <= r_v1;
            if (pipe_ctl.ld3) r_v3 <= r_v2;
        end
    end

    // Position counters. A counter left outside a frame that has shrunk
    // since restarts at zero before the pixel uses it.
    always_comb begin
        col_eff = (DW'(r_col) >= cfg_width)  ? '0 : r_col;
        row_eff = (DW'(r_row) >= cfg_height) ? '0 : r_row;
        col_end = (DW'(col_eff) == cfg_width - DW'(1));
        row_end = (DW'(row_eff) == cfg_height - DW'(1));
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : row_eff + CW'(1);
        end else begin
            n_col = col_eff + CW'(1);
            n_row = row_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1: capture the item with its source position.
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r1_luma <= i_luma;
            r1_cb   <= i_chroma_blue;
            r1_cr   <= i_chroma_red;
            r1_col  <= col_eff;
            r1_row  <= row_eff;
            r1_last <= col_end && row_end;
        end
    end

    // Stages 2 and 3: color conversion and destination addressing side by side.
    yuvrgb_color u_color (
        .i_clk        (i_clk),
        .i_ctl        (pipe_ctl),
        .i_luma       (r1_luma),
        .i_cb         (r1_cb),
        .i_cr         (r1_cr),
        .o_pixel_word (o_pixel_word)
    );

    yuvrgb_addr #(
        .MAX_DIM (MAX_DIM),
        .DW      (DW),
        .CW      (CW)
    ) u_addr (
        .i_clk        (i_clk),
        .i_ctl        (pipe_ctl),
        .i_width      (cfg_width),
        .i_height     (cfg_height),
        .i_rot        (cfg_rot),
        .i_flip_h     (cfg_flip_h),
        .i_flip_v     (cfg_flip_v),
        .i_col        (r1_col),
        .i_row        (r1_row),
        .i_last       (r1_last),
        .o_dest_index (o_dest_index),
        .o_frame_last (o_frame_last)
    );

    assign o_out_valid = r_v3;

`ifndef ASSERT_OFF
    // the input side is held back only by a full pipeline facing a stalled consumer
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && o_out_valid && i_out_stall))
        else $error("input stalled without downstream backpressure");

    // every delivered pixel is opaque
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pixel_word[31:24] == yuvrgb_pkg::ALPHA_OPAQUE))
        else $error("alpha byte not opaque");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // an accepted item reaches stage 1 on the next edge
    a_stage1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v1)
        else $error("accepted item lost at stage 1");
`endif

endmodule

/* sv/yuvrgb_cfg.sv */
// ----------------------------------------------------------------------------
// yuvrgb_cfg
// Configuration registers; frame sizes are stored already clamped to
// 1..MAX_DIM.
// ----------------------------------------------------------------------------
module yuvrgb_cfg #(
    parameter int MAX_DIM = 4096,
    parameter int DW      = $clog2(MAX_DIM + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [yuvrgb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [yuvrgb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [DW-1:0]                      o_width,
    output logic [DW-1:0]                      o_height,
    output yuvrgb_pkg::t_rot                   o_rot,
    output logic                               o_flip_h,
    output logic                               o_flip_v
);
    localparam int CMP_W = (DW > yuvrgb_pkg::CFG_DATA_W) ? DW : yuvrgb_pkg::CFG_DATA_W;

    logic [DW-1:0]          r_width;
    logic [DW-1:0]          r_height;
    yuvrgb_pkg::t_rot       r_rot;
    logic                   r_flip_h;
    logic                   r_flip_v;

    // zero acts as one, oversize acts as MAX_DIM
    function automatic logic [DW-1:0] eff_dim(input logic [yuvrgb_pkg::CFG_DATA_W-1:0] v);
        logic [DW-1:0] res;
        if (v == '0) begin
            res = DW'(1);
        end else if (CMP_W'(v) > CMP_W'(MAX_DIM)) begin
            res = DW'(MAX_DIM);
        end else begin
            res = DW'(v);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= eff_dim(yuvrgb_pkg::WIDTH_RESET);
            r_height <= eff_dim(yuvrgb_pkg::HEIGHT_RESET);
            r_rot    <= yuvrgb_pkg::ROT_0;
            r_flip_h <= 1'b0;
            r_flip_v <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                yuvrgb_pkg::CFG_FRAME_WIDTH:     r_width  <= eff_dim(i_cfg_data);
                yuvrgb_pkg::CFG_FRAME_HEIGHT:    r_height <= eff_dim(i_cfg_data);
                yuvrgb_pkg::CFG_ROTATION_MODE:   r_rot    <= yuvrgb_pkg::t_rot'(i_cfg_data[1:0]);
                yuvrgb_pkg::CFG_FLIP_HORIZONTAL: r_flip_h <= i_cfg_data[0];
                yuvrgb_pkg::CFG_FLIP_VERTICAL:   r_flip_v <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_width  = r_width;
    assign o_height = r_height;
    assign o_rot    = r_rot;
    assign o_flip_h = r_flip_h;
    assign o_flip_v = r_flip_v;

endmodule

/* sv/yuvrgb_color.sv */
// ----------------------------------------------------------------------------
// yuvrgb_color
// Two-stage color path: chroma products, then shift, add and saturate into
// the packed RGBA word.
// ----------------------------------------------------------------------------
module yuvrgb_color (
    input  logic                                i_clk,
    input  yuvrgb_pkg::t_pipe_ctl               i_ctl,
    input  logic [yuvrgb_pkg::PIX_W-1:0]        i_luma,
    input  logic [yuvrgb_pkg::PIX_W-1:0]        i_cb,
    input  logic [yuvrgb_pkg::PIX_W-1:0]        i_cr,
    output logic [yuvrgb_pkg::WORD_W-1:0]       o_pixel_word
);
    localparam int PW = yuvrgb_pkg::PROD_W;

    logic signed [yuvrgb_pkg::PIX_W:0] u9, v9;
    logic signed [PW-1:0] u18, v18;
    logic signed [PW-1:0] n_pr, n_pg, n_pb;
    logic signed [PW-1:0] r_pr, r_pg, r_pb;
    logic [yuvrgb_pkg::PIX_W-1:0] r_luma;
    logic signed [PW-1:0] y18, sum_r, sum_g, sum_b;
    logic [yuvrgb_pkg::WORD_W-1:0] n_word, r_word;

    always_comb begin
        u9   = $signed({1'b0, i_cb}) - yuvrgb_pkg::CHROMA_OFFSET;
        v9   = $signed({1'b0, i_cr}) - yuvrgb_pkg::CHROMA_OFFSET;
        u18  = PW'(u9);
        v18  = PW'(v9);
        n_pr = yuvrgb_pkg::COEF_RV * v18;
        n_pg = yuvrgb_pkg::COEF_GU * u18 + yuvrgb_pkg::COEF_GV * v18;
        n_pb = yuvrgb_pkg::COEF_BU * u18;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_luma <= i_luma;
            r_pr   <= n_pr;
            r_pg   <= n_pg;
            r_pb   <= n_pb;
        end
    end

    // arithmetic shift gives the floor of the division by 256
    always_comb begin
        y18    = $signed({{(PW - yuvrgb_pkg::PIX_W){1'b0}}, r_luma});
        sum_r  = y18 + (r_pr >>> yuvrgb_pkg::FRAC_W);
        sum_g  = y18 - (r_pg >>> yuvrgb_pkg::FRAC_W);
        sum_b  = y18 + (r_pb >>> yuvrgb_pkg::FRAC_W);
        n_word = {yuvrgb_pkg::ALPHA_OPAQUE, yuvrgb_pkg::sat8(sum_b),
                  yuvrgb_pkg::sat8(sum_g), yuvrgb_pkg::sat8(sum_r)};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_word <= n_word;
        end
    end

    assign o_pixel_word = r_word;

endmodule

/* sv/yuvrgb_addr.sv */
// ----------------------------------------------------------------------------
// yuvrgb_addr
// Two-stage address path: mirror and rotate the source position, then
// multiply-add into the destination index.
// ----------------------------------------------------------------------------
module yuvrgb_addr #(
    parameter int MAX_DIM = 4096,
    parameter int DW      = $clog2(MAX_DIM + 1),
    parameter int CW      = $clog2(MAX_DIM)
) (
    input  logic                                i_clk,
    input  yuvrgb_pkg::t_pipe_ctl               i_ctl,
    input  logic [DW-1:0]                       i_width,
    input  logic [DW-1:0]                       i_height,
    input  yuvrgb_pkg::t_rot                    i_rot,
    input  logic                                i_flip_h,
    input  logic                                i_flip_v,
    input  logic [CW-1:0]                       i_col,
    input  logic [CW-1:0]                       i_row,
    input  logic                                i_last,
    output logic [yuvrgb_pkg::INDEX_W-1:0]      o_dest_index,
    output logic                                o_frame_last
);
    localparam int SUM_W = (CW + DW + 1 > yuvrgb_pkg::INDEX_W) ?
                           CW + DW + 1 : yuvrgb_pkg::INDEX_W;

    logic [DW-1:0] w_m1, h_m1;
    logic [CW-1:0] tx, ty;
    logic [CW-1:0] n_fx, n_fy, r_fx, r_fy;
    logic [DW-1:0] n_ow, r_ow;
    logic          r_last2;
    logic [SUM_W-1:0] idx_sum;
    logic [yuvrgb_pkg::INDEX_W-1:0] r_index;
    logic          r_last3;

    always_comb begin
        w_m1 = i_width - DW'(1);
        h_m1 = i_height - DW'(1);
        tx   = i_flip_h ? CW'(w_m1 - DW'(i_col)) : i_col;
        ty   = i_flip_v ? CW'(h_m1 - DW'(i_row)) : i_row;
        unique case (i_rot)
            yuvrgb_pkg::ROT_90: begin
                n_ow = i_height;
                n_fx = CW'(h_m1 - DW'(ty));
                n_fy = tx;
            end
            yuvrgb_pkg::ROT_180: begin
                n_ow = i_width;
                n_fx = CW'(w_m1 - DW'(tx));
                n_fy = CW'(h_m1 - DW'(ty));
            end
            yuvrgb_pkg::ROT_270: begin
                n_ow = i_height;
                n_fx = ty;
                n_fy = CW'(w_m1 - DW'(tx));
            end
            default: begin
                n_ow = i_width;
                n_fx = tx;
                n_fy = ty;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_fx    <= n_fx;
            r_fy    <= n_fy;
            r_ow    <= n_ow;
            r_last2 <= i_last;
        end
    end

    assign idx_sum = SUM_W'(r_fy) * SUM_W'(r_ow) + SUM_W'(r_fx);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_index <= idx_sum[yuvrgb_pkg::INDEX_W-1:0];
            r_last3 <= r_last2;
        end
    end

    assign o_dest_index = r_index;
    assign o_frame_last = r_last3;

endmodule
